// ===== src/adc_pkg.sv =====
// Package for the audio dynamics compressor: types, constants and the control program.
`default_nettype none
package adc_pkg;

	localparam int unsigned SMP_W   = 16;
	localparam int unsigned COEF_W  = 24;
	localparam int unsigned ENV_W   = 24;
	localparam int unsigned THR_W   = 16;
	localparam int unsigned RATIO_W = 5;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned PC_W    = 4;
	localparam int unsigned CNT_W   = 4;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;

	// register indexes on the configuration port
	localparam logic [1:0] REG_ATTACK  = 2'd0;
	localparam logic [1:0] REG_RELEASE = 2'd1;
	localparam logic [1:0] REG_THRESH  = 2'd2;
	localparam logic [1:0] REG_RATIO   = 2'd3;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL_ENV,
		OP_MUL_MAG,
		OP_ENV_UPD,
		OP_MUL_DEN,
		OP_MUL_NUM,
		OP_DIV,
		OP_GAIN,
		OP_MUL_OUT,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_NO_IN,
		COND_NO_COMP,
		COND_DIV_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ctrl_word_t;

	localparam logic [PC_W-1:0] STEP_LOAD    = 4'd0;
	localparam logic [PC_W-1:0] STEP_MUL_ENV = 4'd1;
	localparam logic [PC_W-1:0] STEP_MUL_MAG = 4'd2;
	localparam logic [PC_W-1:0] STEP_ENV_UPD = 4'd3;
	localparam logic [PC_W-1:0] STEP_MUL_DEN = 4'd4;
	localparam logic [PC_W-1:0] STEP_MUL_NUM = 4'd5;
	localparam logic [PC_W-1:0] STEP_DIV     = 4'd6;
	localparam logic [PC_W-1:0] STEP_GAIN    = 4'd7;
	localparam logic [PC_W-1:0] STEP_MUL_OUT = 4'd8;
	localparam logic [PC_W-1:0] STEP_EMIT    = 4'd9;
	localparam logic [PC_W-1:0] LAST_STEP    = STEP_EMIT;

	// control store: a true condition jumps to target, otherwise the next step
	function automatic ctrl_word_t program_word(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		unique case (pc)
			STEP_LOAD:    w = '{OP_LOAD,    COND_NO_IN,    STEP_LOAD};
			STEP_MUL_ENV: w = '{OP_MUL_ENV, COND_NEVER,    STEP_LOAD};
			STEP_MUL_MAG: w = '{OP_MUL_MAG, COND_NEVER,    STEP_LOAD};
			STEP_ENV_UPD: w = '{OP_ENV_UPD, COND_NO_COMP,  STEP_MUL_OUT};
			STEP_MUL_DEN: w = '{OP_MUL_DEN, COND_NEVER,    STEP_LOAD};
			STEP_MUL_NUM: w = '{OP_MUL_NUM, COND_NEVER,    STEP_LOAD};
			STEP_DIV:     w = '{OP_DIV,     COND_DIV_MORE, STEP_DIV};
			STEP_GAIN:    w = '{OP_GAIN,    COND_NEVER,    STEP_LOAD};
			STEP_MUL_OUT: w = '{OP_MUL_OUT, COND_NEVER,    STEP_LOAD};
			STEP_EMIT:    w = '{OP_EMIT,    COND_OUT_BUSY, STEP_EMIT};
			default:      w = '{OP_NOP,     COND_NEVER,    STEP_LOAD};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== src/audio_dynamics_compressor_top.sv =====
// Steps per request: accept, envelope products and update; when the envelope is above
// the threshold, divisor and dividend products, the restoring divider and the gain limit;
// then the output product and emit. The step sequencer handles one request at a time.
// The result sits in an output register, so the next request is taken while it waits.
// Reset (arst_n low, asynchronous): envelope cleared, registers to their defaults,
// sequencer at its load step, output empty.
`default_nettype none
module audio_dynamics_compressor_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [23:0] cfg_wdata,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // [15:0] sample_out, [31:16] applied_gain
);

	// configuration registers
	logic [adc_pkg::COEF_W-1:0]  attack_q;
	logic [adc_pkg::COEF_W-1:0]  release_q;
	logic [adc_pkg::THR_W-1:0]   thresh_q;
	logic [adc_pkg::RATIO_W-1:0] ratio_q;

	// sequencer
	logic [adc_pkg::PC_W-1:0]  pc_q;
	logic [adc_pkg::PC_W-1:0]  pc_next;
	adc_pkg::ctrl_word_t       ctl;
	logic                      cond_true;
	logic                      in_acc;
	logic                      out_free;

	// datapath
	logic [adc_pkg::ENV_W-1:0]   env_q;
	logic signed [15:0]          x_q;
	logic [adc_pkg::ENV_W-1:0]   mag_q;
	logic [adc_pkg::COEF_W-1:0]  coef_q;
	logic [48:0]                 acc_q;
	logic [28:0]                 den_q;
	logic [29:0]                 rem_q;
	logic [adc_pkg::GAIN_W-1:0]  quo_q;
	logic [adc_pkg::CNT_W-1:0]   cnt_q;
	logic [adc_pkg::GAIN_W-1:0]  gain_q;
	logic signed [31:0]          prod_q;
	logic                        out_valid_q;
	logic [31:0]                 out_data_q;

	logic [adc_pkg::ENV_W-1:0]   env_new;
	logic [adc_pkg::ENV_W-1:0]   thr23;
	logic [adc_pkg::RATIO_W-1:0] ratio_eff;
	logic [16:0]                 x_ext;
	logic [16:0]                 x_abs;
	logic [adc_pkg::ENV_W-1:0]   in_mag;
	logic [24:0]                 mul_a;
	logic [23:0]                 mul_b;
	logic [48:0]                 mul_p;
	logic                        div_ge;
	logic [29:0]                 rem_sel;
	logic signed [32:0]          out_prod;
	logic signed [31:0]          rnd;
	logic signed [16:0]          y_full;
	logic [15:0]                 y_sat;

	assign ctl       = adc_pkg::program_word(pc_q);
	assign s_axis_tready = (ctl.op == adc_pkg::OP_LOAD);
	assign in_acc    = s_axis_tvalid & s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	assign thr23     = {thresh_q, 8'd0};
	assign ratio_eff = (ratio_q == '0) ? adc_pkg::RATIO_W'(1) : ratio_q;
	assign env_new   = acc_q[47:24];

	// rectify and widen to Q1.23
	assign x_ext  = {s_axis_tdata[15], s_axis_tdata};
	assign x_abs  = x_ext[16] ? 17'(-x_ext) : x_ext;
	assign in_mag = {x_abs[15:0], 8'd0};

	always_comb begin
		case (ctl.cond)
			adc_pkg::COND_NO_IN:    cond_true = !in_acc;
			adc_pkg::COND_NO_COMP:  cond_true = (env_new <= thr23);
			adc_pkg::COND_DIV_MORE: cond_true = (cnt_q != '0);
			adc_pkg::COND_OUT_BUSY: cond_true = !out_free;
			default:                cond_true = 1'b0;
		endcase
	end

	always_comb begin
		if (cond_true) begin
			pc_next = ctl.target;
		end else if (pc_q == adc_pkg::LAST_STEP) begin
			pc_next = adc_pkg::STEP_LOAD;
		end else begin
			pc_next = pc_q + adc_pkg::PC_W'(1);
		end
	end

	// shared unsigned multiplier
	always_comb begin
		case (ctl.op)
			adc_pkg::OP_MUL_ENV: begin
				mul_a = {1'b0, coef_q};
				mul_b = env_q;
			end
			adc_pkg::OP_MUL_MAG: begin
				mul_a = 25'h1000000 - {1'b0, coef_q};
				mul_b = mag_q;
			end
			adc_pkg::OP_MUL_DEN: begin
				mul_a = 25'(ratio_eff);
				mul_b = env_q;
			end
			adc_pkg::OP_MUL_NUM: begin
				mul_a = 25'(ratio_eff);
				mul_b = thr23;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = 49'(mul_a) * 49'(mul_b);

	// one restoring step per cycle
	assign div_ge  = (rem_q >= {1'b0, den_q});
	assign rem_sel = div_ge ? (rem_q - {1'b0, den_q}) : rem_q;

	assign out_prod = $signed({{17{x_q[15]}}, x_q}) * $signed({17'd0, gain_q});
	assign rnd      = prod_q + 32'sd16384;
	assign y_full   = rnd[31:15];
	always_comb begin
		if (y_full[16] != y_full[15]) begin
			y_sat = y_full[16] ? 16'h8000 : 16'h7FFF;
		end else begin
			y_sat = y_full[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= 24'd16431306;
			release_q <= 24'd16773721;
			thresh_q  <= 16'd16384;
			ratio_q   <= 5'd4;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				adc_pkg::REG_ATTACK:  attack_q  <= cfg_wdata;
				adc_pkg::REG_RELEASE: release_q <= cfg_wdata;
				adc_pkg::REG_THRESH:  thresh_q  <= cfg_wdata[15:0];
				adc_pkg::REG_RATIO:   ratio_q   <= cfg_wdata[4:0];
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= adc_pkg::STEP_LOAD;
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (ctl.op == adc_pkg::OP_ENV_UPD) begin
				env_q <= env_new;
			end
			if (ctl.op == adc_pkg::OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (ctl.op)
			adc_pkg::OP_LOAD: begin
				if (in_acc) begin
					x_q    <= s_axis_tdata;
					mag_q  <= in_mag;
					coef_q <= (in_mag > env_q) ? attack_q : release_q;
				end
			end
			adc_pkg::OP_MUL_ENV: acc_q <= mul_p;
			adc_pkg::OP_MUL_MAG: acc_q <= acc_q + mul_p + 49'h800000;
			adc_pkg::OP_ENV_UPD: gain_q <= adc_pkg::UNITY_GAIN;
			adc_pkg::OP_MUL_DEN: den_q <= mul_p[28:0];
			adc_pkg::OP_MUL_NUM: begin
				// thr*r + (env - thr); env is above thr on this path
				rem_q <= mul_p[29:0] + 30'(env_q) - 30'(thr23);
				cnt_q <= '1;
			end
			adc_pkg::OP_DIV: begin
				rem_q <= {rem_sel[28:0], 1'b0};
				quo_q <= {quo_q[14:0], div_ge};
				cnt_q <= cnt_q - adc_pkg::CNT_W'(1);
			end
			adc_pkg::OP_GAIN: begin
				gain_q <= (quo_q > adc_pkg::UNITY_GAIN) ? adc_pkg::UNITY_GAIN : quo_q;
			end
			adc_pkg::OP_MUL_OUT: prod_q <= out_prod[31:0];
			adc_pkg::OP_EMIT: begin
				if (out_free) begin
					out_data_q <= {gain_q, y_sat};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> pc_q == adc_pkg::STEP_MUL_ENV)
		else $error("accepted request did not start the sequence");

	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= 24'h800000)
		else $error("envelope above unity");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == adc_pkg::STEP_DIV) |-> (rem_q < {den_q, 1'b0}))
		else $error("divider remainder out of range");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == adc_pkg::STEP_MUL_OUT) |-> (gain_q <= adc_pkg::UNITY_GAIN))
		else $error("gain above unity");

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(pc_q) == adc_pkg::STEP_EMIT)
		else $error("result raised outside the emit step");

endmodule
`default_nettype wire

// ===== bench/tb_audio_dynamics_compressor_top.sv =====
// Testbench for the compressor: a directed script, then random register phases, all results checked.
`default_nettype none
module tb_audio_dynamics_compressor_top;

	localparam logic [1:0]  REG_ATTACK  = adc_pkg::REG_ATTACK;
	localparam logic [1:0]  REG_RELEASE = adc_pkg::REG_RELEASE;
	localparam logic [1:0]  REG_THRESH  = adc_pkg::REG_THRESH;
	localparam logic [1:0]  REG_RATIO   = adc_pkg::REG_RATIO;
	localparam logic [15:0] UNITY_GAIN  = adc_pkg::UNITY_GAIN;

	localparam int QUIET_LIMIT     = 2000;
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 52;
	localparam int SCRIPT_LEN      = 30;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_PREDICT,
		ROW_TYPED
	} row_kind_t;

	// value holds the register data for a write, the sample in its low bits otherwise
	typedef struct packed {
		row_kind_t    kind;
		logic [1:0]   addr;
		logic [23:0]  value;
		logic [15:0]  out_val;
		logic [15:0]  gain_val;
	} script_row_t;

	typedef struct {
		logic [15:0] smp;
		logic [15:0] gain;
	} gain_pair_t;

	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{ROW_TYPED,   REG_ATTACK,  24'h000000, 16'h0000, UNITY_GAIN}, // silence from reset
		'{ROW_PREDICT, REG_ATTACK,  24'h007FFF, 16'h0000, 16'h0000},
		'{ROW_PREDICT, REG_ATTACK,  24'h008000, 16'h0000, 16'h0000},
		'{ROW_PREDICT, REG_ATTACK,  24'h00FFFF, 16'h0000, 16'h0000},
		'{ROW_PREDICT, REG_ATTACK,  24'h000001, 16'h0000, 16'h0000},
		'{ROW_WRITE,   REG_ATTACK,  24'h000000, 16'h0000, 16'h0000}, // envelope jumps to peak
		'{ROW_PREDICT, REG_ATTACK,  24'h008000, 16'h0000, 16'h0000},
		'{ROW_WRITE,   REG_RELEASE, 24'hFFFFFF, 16'h0000, 16'h0000},
		'{ROW_PREDICT, REG_ATTACK,  24'h000000, 16'h0000, 16'h0000},
		'{ROW_PREDICT, REG_ATTACK,  24'h004000, 16'h0000, 16'h0000},
		'{ROW_WRITE,   REG_RATIO,   24'd0,      16'h0000, 16'h0000},
		'{ROW_TYPED,   REG_ATTACK,  24'h007FFF, 16'h7FFF, UNITY_GAIN}, // ratio zero acts as one
		'{ROW_WRITE,   REG_RATIO,   24'd31,     16'h0000, 16'h0000},
		'{ROW_PREDICT, REG_ATTACK,  24'h008000, 16'h0000, 16'h0000},
		'{ROW_WRITE,   REG_THRESH,  24'd0,      16'h0000, 16'h0000},
		'{ROW_WRITE,   REG_RATIO,   24'd16,     16'h0000, 16'h0000},
		'{ROW_PREDICT, REG_ATTACK,  24'h000100, 16'h0000, 16'h0000},
		'{ROW_WRITE,   REG_RELEASE, 24'd0,      16'h0000, 16'h0000},
		'{ROW_WRITE,   REG_RATIO,   24'd2,      16'h0000, 16'h0000},
		'{ROW_TYPED,   REG_ATTACK,  24'h004000, 16'd8192, 16'd16384},  // zero threshold, half gain
		'{ROW_TYPED,   REG_ATTACK,  24'h000000, 16'h0000, UNITY_GAIN}, // empty envelope not above zero
		'{ROW_WRITE,   REG_THRESH,  24'h00FFFF, 16'h0000, 16'h0000},
		'{ROW_TYPED,   REG_ATTACK,  24'h007FFF, 16'h7FFF, UNITY_GAIN}, // threshold above unity
		'{ROW_TYPED,   REG_ATTACK,  24'h008000, 16'h8000, UNITY_GAIN},
		'{ROW_WRITE,   REG_THRESH,  24'h008000, 16'h0000, 16'h0000},
		'{ROW_TYPED,   REG_ATTACK,  24'h008000, 16'h8000, UNITY_GAIN}, // full scale equals threshold
		'{ROW_PREDICT, REG_ATTACK,  24'h00FFFF, 16'h0000, 16'h0000},
		'{ROW_WRITE,   REG_ATTACK,  24'hFFFFFF, 16'h0000, 16'h0000},
		'{ROW_PREDICT, REG_ATTACK,  24'h007FFF, 16'h0000, 16'h0000},
		'{ROW_PREDICT, REG_ATTACK,  24'h008001, 16'h0000, 16'h0000}
	};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_wen       = 1'b0;
	logic [1:0]  cfg_addr      = REG_ATTACK;
	logic [23:0] cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;  // [15:0] sample_in
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [15:0] sample_out, [31:16] applied_gain

	// predictor copy of the block's registers and envelope
	logic [23:0] attack_q  = 24'd16431306;
	logic [23:0] release_q = 24'd16773721;
	logic [15:0] thresh_q  = 16'd16384;
	logic [4:0]  ratio_q   = 5'd4;
	logic [23:0] env_q     = '0;

	gain_pair_t  predicted_outputs [$];
	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	bit          steady         = 1'b0;

	audio_dynamics_compressor_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// envelope follower, gain and scaling for one sample; advances env_q
	function automatic void compress_sample(input logic [15:0] raw,
			output logic [15:0] smp_o, output logic [15:0] gain_o);
		longint x, mag, env, coef, thr, r, gain, y;
		x    = longint'($signed(raw));
		mag  = (x < 0 ? -x : x) << 8;
		env  = longint'(env_q);
		coef = (mag > env) ? longint'(attack_q) : longint'(release_q);
		env  = (coef * env + ((64'sd1 << 24) - coef) * mag + (64'sd1 << 23)) >>> 24;
		env_q = 24'(env);
		env  = longint'(env_q);
		thr  = longint'(thresh_q) << 8;
		r    = (ratio_q == 5'd0) ? 1 : longint'(ratio_q);
		gain = longint'(UNITY_GAIN);
		if (env > thr) begin
			gain = ((thr * r + env - thr) << 15) / (env * r);
			if (gain > longint'(UNITY_GAIN))
				gain = longint'(UNITY_GAIN);
		end
		y = (x * gain + 16384) >>> 15;
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		smp_o  = 16'(y);
		gain_o = 16'(gain);
	endfunction

	function automatic logic [23:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return 24'hFFFFFF - 24'($urandom_range(0, 1 << 20));
			default: return 24'($urandom);
		endcase
	endfunction

	// leaves wen high; the next sample or drain drops it
	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_ATTACK:  attack_q  = val;
			REG_RELEASE: release_q = val;
			REG_THRESH:  thresh_q  = val[15:0];
			REG_RATIO:   ratio_q   = val[4:0];
		endcase
		@(posedge clk);
	endtask

	task automatic push_sample(input logic [15:0] raw, input bit typed,
			input logic [15:0] t_out, input logic [15:0] t_gain);
		gain_pair_t want;
		cfg_wen <= 1'b0;
		while (!steady && $urandom_range(0, 99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		compress_sample(raw, want.smp, want.gain);
		if (typed) begin
			want.smp  = t_out;
			want.gain = t_gain;
		end
		predicted_outputs.push_back(want);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= raw;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
	endtask

	task automatic drain_block();
		cfg_wen       <= 1'b0;
		s_axis_tvalid <= 1'b0;
		while (predicted_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
	end

	always @(posedge clk) begin : check_results
		gain_pair_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (predicted_outputs.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				mismatch_count++;
			end else begin
				want = predicted_outputs.pop_front();
				if (m_axis_tdata[15:0] !== want.smp) begin
					$error("sample_out: expected %0d, got %0d",
						$signed(want.smp), $signed(m_axis_tdata[15:0]));
					mismatch_count++;
				end
				if (m_axis_tdata[31:16] !== want.gain) begin
					$error("applied_gain: expected %0d, got %0d", want.gain, m_axis_tdata[31:16]);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready)
				|| cfg_wen)
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		logic [15:0] smp;
		logic [15:0] thr_val;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].kind == ROW_WRITE) begin
				drain_block();
				write_reg(SCRIPT[i].addr, SCRIPT[i].value);
			end else
				push_sample(SCRIPT[i].value[15:0], SCRIPT[i].kind == ROW_TYPED,
					SCRIPT[i].out_val, SCRIPT[i].gain_val);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_block();
			steady = (phase == 4 || phase == 5);
			case ($urandom_range(0, 5))
				0: thr_val = 16'd0;
				1: thr_val = 16'hFFFF;
				2: thr_val = 16'd32768;
				3: thr_val = 16'($urandom_range(0, 65535));
				default: thr_val = 16'($urandom_range(0, 32768));
			endcase
			write_reg(REG_ATTACK, pick_coef());
			write_reg(REG_RELEASE, pick_coef());
			write_reg(REG_THRESH, {8'h00, thr_val});
			write_reg(REG_RATIO, 24'($urandom_range(0, 31)));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// loud bursts drive the envelope over the threshold
				case ($urandom_range(0, 9))
					0, 1, 2, 3: smp = 16'($urandom);
					4, 5, 6: smp = 16'($urandom_range(24000, 32767));
					7, 8: smp = 16'($urandom_range(0, 511));
					default: smp = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
				endcase
				if ($urandom_range(0, 1) != 0)
					smp = -smp;
				push_sample(smp, 1'b0, 16'h0000, 16'h0000);
			end
		end

		drain_block();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
src/adc_pkg.sv
src/audio_dynamics_compressor_top.sv
bench/tb_audio_dynamics_compressor_top.sv
